// ----- hw/rtl/hds_pkg.sv -----
// shared constants and sequencer codes for the heat diffusion stencil step
package hds_pkg;

    localparam int TEMP_W = 20;
    localparam int DIFF_W = 16;
    localparam int RATE_W = 24;
    localparam int DT_W   = 16;
    localparam int SIZE_W = 7;
    localparam int ENTRY_W = TEMP_W + 1;
    localparam int COEF_W  = DIFF_W + RATE_W;

    localparam logic [1:0] REG_SIZE_X    = 2'd0;
    localparam logic [1:0] REG_SIZE_Y    = 2'd1;
    localparam logic [1:0] REG_SIZE_Z    = 2'd2;
    localparam logic [1:0] REG_TIME_STEP = 2'd3;

    localparam logic OP_CELL  = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD   = 3'd1;
    localparam logic [2:0] S_ACC  = 3'd2;
    localparam logic [2:0] S_LAP  = 3'd3;
    localparam logic [2:0] S_MLO  = 3'd4;
    localparam logic [2:0] S_MHI  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    localparam logic [2:0] NB_C  = 3'd0;
    localparam logic [2:0] NB_XP = 3'd1;
    localparam logic [2:0] NB_XM = 3'd2;
    localparam logic [2:0] NB_YP = 3'd3;
    localparam logic [2:0] NB_YM = 3'd4;
    localparam logic [2:0] NB_ZM = 3'd5;

endpackage

// ----- hw/rtl/heat_diffusion_stencil_step.sv -----
// Heat diffusion stencil step: cells arrive in raster order, x fastest, and each
// result leaves one plane behind its input. A cell that completes no result is
// stored in the accept cycle and the block is ready again in the next one. A
// cell or drain request that produces a result keeps the input closed until its
// result is loaded into the output register: six reads of the plane memory
// through its single read port (center and five stored neighbors), a step to
// add the last of them, then the Laplacian, the diffusivity multiply, a two-part
// multiply by the time step and a step that rounds and saturates. The result
// goes to an output register and the block takes the next request while it waits
// there; only when that register still holds an unaccepted result at the end of
// the next one does the block wait for it before reopening the input. Two planes
// of temperatures and one plane of coefficients are held in memories that need no
// clearing after reset. Requests that do nothing are taken and the input stays
// open.
module heat_diffusion_stencil_step
    import hds_pkg::*;
#(
    parameter int MAX_X = 64,
    parameter int MAX_Y = 64,
    parameter int MAX_Z = 64
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     opcode,
    input  logic [TEMP_W-1:0]        temperature,
    input  logic                     void_cell,
    input  logic [DIFF_W-1:0]        diffusivity,
    input  logic signed [RATE_W-1:0] heat_rate,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [TEMP_W-1:0]        new_temperature,
    output logic                     void_out,
    output logic                     last_cell,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [1:0]               cfg_index,
    input  logic [DT_W-1:0]          cfg_data
);

    localparam int XW  = (MAX_X > 1) ? $clog2(MAX_X) : 1;
    localparam int YW  = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
    localparam int ZW  = (MAX_Z > 1) ? $clog2(MAX_Z) : 1;
    localparam int DXW = $clog2(MAX_X + 1);
    localparam int DYW = $clog2(MAX_Y + 1);
    localparam int DZW = $clog2(MAX_Z + 1);
    localparam int PAW = 1 + YW + XW;
    localparam int CAW = YW + XW;
    localparam int CWX = (DXW > SIZE_W) ? DXW : SIZE_W;
    localparam int CWY = (DYW > SIZE_W) ? DYW : SIZE_W;
    localparam int CWZ = (DZW > SIZE_W) ? DZW : SIZE_W;

    logic [SIZE_W-1:0] size_x_reg, size_y_reg, size_z_reg;
    logic [DT_W-1:0]   dt_reg;
    logic [2:0]        state_reg;
    logic [2:0]        rd_cnt_reg;

    logic [XW-1:0] ix_reg, ox_reg;
    logic [YW-1:0] iy_reg, oy_reg;
    logic [ZW-1:0] iz_reg, oz_reg;
    logic          in_done_reg;

    logic [TEMP_W-1:0]        ent_temp_reg;
    logic                     ent_void_reg;
    logic [DIFF_W-1:0]        ent_diff_reg;
    logic [RATE_W-1:0]        ent_rate_reg;
    logic                     is_cell_reg;

    logic [TEMP_W-1:0]        tc_reg;
    logic                     cvoid_reg;
    logic [22:0]              sum_reg;
    logic [DIFF_W-1:0]        alpha_reg;
    logic signed [RATE_W-1:0] rate_reg;
    logic signed [24:0]       lap_reg;
    logic signed [43:0]       inner_reg;
    logic [39:0]              lo_reg;
    logic signed [37:0]       delta_reg;

    logic                     out_valid_reg;
    logic [TEMP_W-1:0]        out_temp_reg;
    logic                     out_void_reg;
    logic                     out_last_reg;

    logic [CWX-1:0] sxe;
    logic [CWY-1:0] sye;
    logic [CWZ-1:0] sze;
    logic [DXW-1:0] sx;
    logic [DYW-1:0] sy;
    logic [DZW-1:0] sz;

    always_comb
    begin
        sxe = CWX'(size_x_reg);
        sye = CWY'(size_y_reg);
        sze = CWZ'(size_z_reg);
        if (sxe == '0)
            sxe = CWX'(1);
        else if (sxe > CWX'(MAX_X))
            sxe = CWX'(MAX_X);
        if (sye == '0)
            sye = CWY'(1);
        else if (sye > CWY'(MAX_Y))
            sye = CWY'(MAX_Y);
        if (sze == '0)
            sze = CWZ'(1);
        else if (sze > CWZ'(MAX_Z))
            sze = CWZ'(MAX_Z);
        sx = DXW'(sxe);
        sy = DYW'(sye);
        sz = DZW'(sze);
    end

    // input and output position edges
    logic ix_end, iy_end, iz_end, ox_end, oy_end, oz_end, out_last;
    assign ix_end   = (DXW'(ix_reg) + DXW'(1)) == sx;
    assign iy_end   = (DYW'(iy_reg) + DYW'(1)) == sy;
    assign iz_end   = (DZW'(iz_reg) + DZW'(1)) == sz;
    assign ox_end   = (DXW'(ox_reg) + DXW'(1)) == sx;
    assign oy_end   = (DYW'(oy_reg) + DYW'(1)) == sy;
    assign oz_end   = (DZW'(oz_reg) + DZW'(1)) == sz;
    assign out_last = ox_end && oy_end && oz_end;

    // neighbor presence, indexed by read slot
    logic [7:0] nb_ok;
    always_comb
    begin
        nb_ok        = '0;
        nb_ok[NB_C]  = 1'b1;
        nb_ok[NB_XP] = !ox_end;
        nb_ok[NB_XM] = (ox_reg != '0);
        nb_ok[NB_YP] = !oy_end;
        nb_ok[NB_YM] = (oy_reg != '0);
        nb_ok[NB_ZM] = (oz_reg != '0);
    end

    logic [PAW-1:0] p_raddr;
    always_comb
    begin
        case (rd_cnt_reg)
            NB_XP:   p_raddr = {oz_reg[0], oy_reg, ox_reg + XW'(1)};
            NB_XM:   p_raddr = {oz_reg[0], oy_reg, ox_reg - XW'(1)};
            NB_YP:   p_raddr = {oz_reg[0], oy_reg + YW'(1), ox_reg};
            NB_YM:   p_raddr = {oz_reg[0], oy_reg - YW'(1), ox_reg};
            NB_ZM:   p_raddr = {~oz_reg[0], oy_reg, ox_reg};
            default: p_raddr = {oz_reg[0], oy_reg, ox_reg};
        endcase
    end

    logic in_fire, out_fire, cfg_fire, fin_go;
    logic go_emit, go_store;
    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_fire   = in_valid && in_ready;
    assign out_fire  = out_valid_reg && out_ready;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign fin_go    = (state_reg == S_FIN) && (!out_valid_reg || out_ready);
    assign go_emit   = in_fire && (((opcode == OP_CELL) && !in_done_reg && (iz_reg != '0))
                       || ((opcode == OP_DRAIN) && in_done_reg));
    assign go_store  = in_fire && (opcode == OP_CELL) && !in_done_reg && (iz_reg == '0);

    // memory write ports
    logic               p_we;
    logic [PAW-1:0]     p_waddr;
    logic [ENTRY_W-1:0] p_wdata, p_rdata;
    logic [CAW-1:0]     c_waddr;
    logic [COEF_W-1:0]  c_wdata, c_rdata;

    always_comb
    begin
        if (go_store)
        begin
            p_wdata = {void_cell, temperature};
            c_wdata = {heat_rate, diffusivity};
        end
        else
        begin
            p_wdata = {ent_void_reg, ent_temp_reg};
            c_wdata = {ent_rate_reg, ent_diff_reg};
        end
    end
    assign p_we    = go_store || (fin_go && is_cell_reg);
    assign p_waddr = {iz_reg[0], iy_reg, ix_reg};
    assign c_waddr = {iy_reg, ix_reg};

    hds_ram #(.W(ENTRY_W), .AW(PAW)) u_plane
    (
        .clk   (clk),
        .we    (p_we),
        .waddr (p_waddr),
        .wdata (p_wdata),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    hds_ram #(.W(COEF_W), .AW(CAW)) u_coef
    (
        .clk   (clk),
        .we    (p_we),
        .waddr (c_waddr),
        .wdata (c_wdata),
        .raddr ({oy_reg, ox_reg}),
        .rdata (c_rdata)
    );

    // datapath terms
    logic [2:0]          nb_idx;
    logic [TEMP_W-1:0]   nb_term, up_term;
    logic signed [41:0]  mul_ab;
    logic signed [39:0]  rate_sh;
    logic signed [19:0]  inner_hi;
    logic signed [36:0]  prod_hi;
    logic [39:0]         lo_rnd;
    logic signed [38:0]  nt;
    logic [TEMP_W-1:0]   nt_sat;

    assign nb_idx   = (state_reg == S_ACC) ? NB_ZM : (rd_cnt_reg - 3'd1);
    assign nb_term  = (nb_ok[nb_idx] && !p_rdata[TEMP_W]) ? p_rdata[TEMP_W-1:0] : tc_reg;
    assign up_term  = (is_cell_reg && !ent_void_reg) ? ent_temp_reg : tc_reg;
    assign mul_ab   = lap_reg * $signed({1'b0, alpha_reg});
    assign rate_sh  = {rate_reg, 16'd0};
    assign inner_hi = inner_reg[43:24];
    assign prod_hi  = inner_hi * $signed({1'b0, dt_reg});
    assign lo_rnd   = lo_reg + 40'h80_0000;
    assign nt       = 39'(delta_reg) + $signed({19'd0, tc_reg});

    always_comb
    begin
        if (nt[38])
            nt_sat = '0;
        else if (|nt[37:TEMP_W])
            nt_sat = '1;
        else
            nt_sat = nt[TEMP_W-1:0];
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            ent_temp_reg <= temperature;
            ent_void_reg <= void_cell;
            ent_diff_reg <= diffusivity;
            ent_rate_reg <= heat_rate;
            is_cell_reg  <= (opcode == OP_CELL);
        end
        if ((state_reg == S_RD && rd_cnt_reg != 3'd0) || state_reg == S_ACC)
        begin
            if (nb_idx == NB_C)
            begin
                tc_reg    <= p_rdata[TEMP_W-1:0];
                cvoid_reg <= p_rdata[TEMP_W];
                sum_reg   <= '0;
                alpha_reg <= c_rdata[DIFF_W-1:0];
                rate_reg  <= c_rdata[COEF_W-1:DIFF_W];
            end
            else
            begin
                sum_reg <= sum_reg + 23'(nb_term);
            end
        end
        if (state_reg == S_LAP)
        begin
            lap_reg <= $signed(25'(sum_reg) + 25'(up_term)) - $signed(25'(tc_reg) * 25'd6);
        end
        if (state_reg == S_MLO)
        begin
            inner_reg <= 44'(mul_ab) + 44'(rate_sh);
        end
        if (state_reg == S_MHI)
        begin
            lo_reg <= 40'(inner_reg[23:0]) * 40'(dt_reg);
        end
        if (state_reg == S_FIN && rd_cnt_reg == 3'd0)
        begin
            delta_reg <= 38'(prod_hi) + 38'({22'd0, lo_rnd[39:24]});
        end
        if (fin_go)
        begin
            out_temp_reg <= cvoid_reg ? '0 : nt_sat;
            out_void_reg <= cvoid_reg;
            out_last_reg <= out_last;
        end
    end

    // sequencer, positions and registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_x_reg    <= SIZE_W'(64);
            size_y_reg    <= SIZE_W'(64);
            size_z_reg    <= SIZE_W'(64);
            dt_reg        <= DT_W'(256);
            state_reg     <= S_IDLE;
            rd_cnt_reg    <= '0;
            ix_reg        <= '0;
            iy_reg        <= '0;
            iz_reg        <= '0;
            ox_reg        <= '0;
            oy_reg        <= '0;
            oz_reg        <= '0;
            in_done_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_fire)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    rd_cnt_reg <= '0;
                    if (go_emit)
                        state_reg <= S_RD;
                end
                S_RD:
                begin
                    rd_cnt_reg <= rd_cnt_reg + 3'd1;
                    if (rd_cnt_reg == NB_ZM)
                        state_reg <= S_ACC;
                end
                S_ACC:
                    state_reg <= S_LAP;
                S_LAP:
                    state_reg <= S_MLO;
                S_MLO:
                    state_reg <= S_MHI;
                S_MHI:
                begin
                    rd_cnt_reg <= '0;
                    state_reg  <= S_FIN;
                end
                S_FIN:
                begin
                    // delta is formed while rd_cnt_reg is zero, then wait for the output slot
                    rd_cnt_reg <= 3'd1;
                    if (fin_go && rd_cnt_reg != 3'd0)
                    begin
                        state_reg     <= S_IDLE;
                        out_valid_reg <= 1'b1;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase

            if (go_store || (fin_go && rd_cnt_reg != 3'd0 && is_cell_reg))
            begin
                if (ix_end)
                begin
                    ix_reg <= '0;
                    if (iy_end)
                    begin
                        iy_reg <= '0;
                        if (iz_end)
                        begin
                            iz_reg      <= '0;
                            in_done_reg <= 1'b1;
                        end
                        else
                            iz_reg <= iz_reg + ZW'(1);
                    end
                    else
                        iy_reg <= iy_reg + YW'(1);
                end
                else
                    ix_reg <= ix_reg + XW'(1);
            end

            if (fin_go && rd_cnt_reg != 3'd0)
            begin
                if (out_last)
                begin
                    ox_reg      <= '0;
                    oy_reg      <= '0;
                    oz_reg      <= '0;
                    ix_reg      <= '0;
                    iy_reg      <= '0;
                    iz_reg      <= '0;
                    in_done_reg <= 1'b0;
                end
                else if (ox_end)
                begin
                    ox_reg <= '0;
                    if (oy_end)
                    begin
                        oy_reg <= '0;
                        oz_reg <= oz_reg + ZW'(1);
                    end
                    else
                        oy_reg <= oy_reg + YW'(1);
                end
                else
                    ox_reg <= ox_reg + XW'(1);
            end

            if (cfg_fire)
            begin
                case (cfg_index)
                    REG_SIZE_X, REG_SIZE_Y, REG_SIZE_Z:
                    begin
                        if (cfg_index == REG_SIZE_X)
                            size_x_reg <= cfg_data[SIZE_W-1:0];
                        else if (cfg_index == REG_SIZE_Y)
                            size_y_reg <= cfg_data[SIZE_W-1:0];
                        else
                            size_z_reg <= cfg_data[SIZE_W-1:0];
                        ix_reg      <= '0;
                        iy_reg      <= '0;
                        iz_reg      <= '0;
                        ox_reg      <= '0;
                        oy_reg      <= '0;
                        oz_reg      <= '0;
                        in_done_reg <= 1'b0;
                    end
                    REG_TIME_STEP:
                        dt_reg <= cfg_data;
                    default:
                        dt_reg <= dt_reg;
                endcase
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign new_temperature = out_temp_reg;
    assign void_out        = out_void_reg;
    assign last_cell       = out_last_reg;

    // a result only starts once a full plane is stored or the volume is in
    a_emit_after_plane: assert property (@(posedge clk) disable iff (!rst_n)
        go_emit |-> (in_done_reg || iz_reg != '0))
        else $error("result started before a plane was stored");

    // the last cell of the volume rewinds the input side
    a_last_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
        (fin_go && rd_cnt_reg != 3'd0 && out_last) |=> (!in_done_reg && iz_reg == '0))
        else $error("volume end did not rewind positions");

    // the plane memory is never written while neighbors are being read
    a_no_write_in_reads: assert property (@(posedge clk) disable iff (!rst_n)
        p_we |-> (state_reg == S_IDLE || state_reg == S_FIN))
        else $error("plane write during neighbor reads");

endmodule

// ----- hw/rtl/hds_ram.sv -----
// single-port-write, single-port-read synchronous memory with registered read
module hds_ram
    import hds_pkg::*;
#(
    parameter int W  = 21,
    parameter int AW = 13
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [W-1:0]  wdata,
    input  logic [AW-1:0] raddr,
    output logic [W-1:0]  rdata
);

    logic [W-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule
